// ----- rtl/glob_star_name_matcher_defines.svh -----
// ----------------------------------------------------------------------------
// Glob star name matcher assertion macros
// Shared concurrent assertion forms, clocked on clk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef GLOB_STAR_NAME_MATCHER_DEFINES_SVH
`define GLOB_STAR_NAME_MATCHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GSNM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GSNM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/gsnm_pkg.sv -----
// ----------------------------------------------------------------------------
// Glob star name matcher package
// Byte codes and register addresses shared by the matcher.
// ----------------------------------------------------------------------------
package gsnm_pkg;

  // Pattern bytes with a special meaning.
  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] DOT_BYTE  = 8'h2E;

  // Number of pattern bytes the register file holds.
  localparam int unsigned BYTES_STORED = 32;

  // Register file geometry: 64-bit registers at 8-byte spacing.
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 6;

  typedef enum logic [2:0] {
    REG_PATTERN_LENGTH   = 3'd0,
    REG_PATTERN_LO       = 3'd1,
    REG_PATTERN_MID_LO   = 3'd2,
    REG_PATTERN_MID_HI   = 3'd3,
    REG_PATTERN_HI       = 3'd4
  } reg_index_t;

endpackage

// ----- rtl/glob_star_name_matcher.sv -----
// ----------------------------------------------------------------------------
// Glob star name matcher
// Matches a streamed file name against a shell wildcard pattern ('*' only)
// by tracking the set of pattern positions the name can reach so far.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake               word
//   in_       input       in_valid / in_stall     name byte, last-byte flag
//   out_      output      out_valid / out_stall   one-bit verdict per name
//   cfg       input       APB (psel/penable)      pattern length and bytes
//
// One name byte is taken per cycle while in_stall is low; a name's verdict is
// registered as its last byte leaves the input register. The rate is set by
// the position-set update, between the input and the state/result registers.
// Reset is synchronous, active low, and clears the pattern to length zero.
// in_stall rises only while a finished verdict is stalled at the output and
// the word held in the input register is a last byte as well.
`include "glob_star_name_matcher_defines.svh"

module glob_star_name_matcher
  import gsnm_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Name byte stream
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_name_byte,
  input  logic                  in_name_end,
  // Verdict stream
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_name_matches,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Usable pattern positions and index width for a position.
  localparam int unsigned LP_POS   = (PATTERN_MAX < BYTES_STORED) ? PATTERN_MAX
                                                                  : BYTES_STORED;
  localparam int unsigned LP_IDX_W = $clog2(LP_POS + 1);
  localparam logic [LP_POS:0] POS_START = (LP_POS + 1)'(1);

  // Kogge-Stone prefix: a position is reachable if it is set or if the
  // position before it is a reachable star.
  function automatic logic [LP_POS:0] star_close(input logic [LP_POS:0] gen_in,
                                                 input logic [LP_POS:0] prop_in);
    logic [LP_POS:0] g;
    logic [LP_POS:0] p;
    logic [LP_POS:0] g2;
    logic [LP_POS:0] p2;
    g = gen_in;
    p = prop_in;
    for (int d = 1; d <= LP_POS; d = d * 2) begin
      g2 = g;
      p2 = p;
      for (int k = d; k <= LP_POS; k++) begin
        g2[k] = g[k] | (p[k] & g[k-d]);
        p2[k] = p[k] & p[k-d];
      end
      g = g2;
      p = p2;
    end
    return g;
  endfunction

  // Configuration registers
  logic [5:0]            cfg_len_r;
  logic [CFG_DATA_W-1:0] pat_w_r [4];

  // Input stage
  logic       s1_v_r;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;

  // Match state
  logic [LP_POS:0] pos_r;
  logic [LP_POS:0] pos_nxt;
  logic            at_start_r;

  // Result register
  logic out_v_r;
  logic match_r;

  logic                cfg_wr;
  logic                s1_move;
  logic [5:0]          len_sat;
  logic [LP_IDX_W-1:0] len_eff;
  logic [LP_POS-1:0]   in_range;
  logic [LP_POS-1:0]   star_m;
  logic [LP_POS-1:0]   lit_m;
  logic [LP_POS:0]     cur_set;
  logic [LP_POS:0]     step_set;
  logic [LP_POS:0]     fin_set;
  logic                dot_block;
  logic                verdict;

  // Register writes and reads.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r  <= '0;
      pat_w_r[0] <= '0;
      pat_w_r[1] <= '0;
      pat_w_r[2] <= '0;
      pat_w_r[3] <= '0;
    end else if (cfg_wr) begin
      case (reg_index_t'(paddr[5:3]))
        REG_PATTERN_LENGTH: cfg_len_r  <= pwdata[5:0];
        REG_PATTERN_LO:     pat_w_r[0] <= pwdata;
        REG_PATTERN_MID_LO: pat_w_r[1] <= pwdata;
        REG_PATTERN_MID_HI: pat_w_r[2] <= pwdata;
        REG_PATTERN_HI:     pat_w_r[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index_t'(paddr[5:3]))
      REG_PATTERN_LENGTH: prdata = CFG_DATA_W'(cfg_len_r);
      REG_PATTERN_LO:     prdata = pat_w_r[0];
      REG_PATTERN_MID_LO: prdata = pat_w_r[1];
      REG_PATTERN_MID_HI: prdata = pat_w_r[2];
      REG_PATTERN_HI:     prdata = pat_w_r[3];
      default:            prdata = '0;
    endcase
  end

  // Effective pattern length and per-position byte classes.
  assign len_sat = (cfg_len_r > 6'(LP_POS)) ? 6'(LP_POS) : cfg_len_r;
  assign len_eff = LP_IDX_W'(len_sat);

  always_comb begin
    for (int i = 0; i < LP_POS; i++) begin
      in_range[i] = (6'(i) < len_sat);
      star_m[i]   = in_range[i] && (pat_w_r[i/8][8*(i%8) +: 8] == STAR_BYTE);
      lit_m[i]    = in_range[i] && (pat_w_r[i/8][8*(i%8) +: 8] != STAR_BYTE)
                    && (pat_w_r[i/8][8*(i%8) +: 8] == s1_byte_r);
    end
  end

  // Position-set update for the word in the input stage.
  assign cur_set   = star_close(pos_r, {star_m, 1'b0});
  assign dot_block = at_start_r && (s1_byte_r == DOT_BYTE) &&
                     !((len_sat != '0) && (pat_w_r[0][7:0] == DOT_BYTE));
  assign step_set  = dot_block ? '0
                   : ({1'b0, cur_set[LP_POS-1:0] & star_m} |
                      {cur_set[LP_POS-1:0] & lit_m, 1'b0});
  assign fin_set   = star_close(step_set, {star_m, 1'b0});
  assign verdict   = fin_set[len_eff];
  assign pos_nxt   = s1_end_r ? POS_START : step_set;

  // Flow control: only a last byte needs room in the result register.
  assign s1_move  = s1_v_r && (!s1_end_r || !out_v_r || !out_stall);
  assign in_stall = s1_v_r && !s1_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (!in_stall) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte_r <= in_name_byte;
      s1_end_r  <= in_name_end;
    end
  end

  // Match state advances once per processed word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= POS_START;
      at_start_r <= 1'b1;
    end else if (s1_move) begin
      pos_r      <= pos_nxt;
      at_start_r <= s1_end_r;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_move && s1_end_r) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_end_r) begin
      match_r <= verdict;
    end
  end

  assign out_valid        = out_v_r;
  assign out_name_matches = match_r;

  // Checks on the internal pipeline.
  `GSNM_ASSERT_SAME(a_stall_only_full, in_stall,
    s1_v_r && s1_end_r && out_v_r && out_stall, "input stalled without cause")
  `GSNM_ASSERT_SAME(a_start_state, at_start_r, pos_r == POS_START,
    "name start without start position set")
  `GSNM_ASSERT_NEXT(a_end_resets, s1_move && s1_end_r,
    at_start_r && out_v_r, "last byte did not restart matching")
  `GSNM_ASSERT_SAME(a_result_from_end, $rose(out_v_r),
    $past(s1_v_r && s1_end_r), "verdict without a last byte")

endmodule

// ----- tb/sv/glob_star_name_matcher_tb.sv -----
// ----------------------------------------------------------------------------
// Glob star name matcher testbench
// Streams file names one byte per word against wildcard patterns loaded over
// the APB port. A scoreboard class tracks the reachable pattern positions of
// its own and checks every verdict in order. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module glob_star_name_matcher_tb;
  import gsnm_pkg::*;

  localparam int unsigned PATTERN_MAX    = 32;
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned TOTAL_WORDS    = 1975;
  localparam int unsigned QUIET_FROM     = 1750;
  localparam int unsigned TIMEOUT_CYCLES = 600000;
  // Address slot past the last register; writes there must be ignored.
  localparam logic [2:0]  REG_UNUSED     = 3'd5;

  typedef logic [7:0] byte_q_t [$];
  typedef logic [7:0] pattern_t [BYTES_STORED];

  // Tracks the set of reachable pattern positions and queues the verdicts.
  class glob_verdict_tracker;
    logic [5:0]  length_reg;
    logic [63:0] words [4];
    logic [32:0] reach;
    bit          at_start;
    logic        pending_verdicts [$];
    int unsigned fails;

    function new();
      length_reg = '0;
      foreach (words[i]) words[i] = '0;
      reach      = 33'd1;
      at_start   = 1'b1;
      fails      = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] value);
      case (idx)
        REG_PATTERN_LENGTH: length_reg = value[5:0];
        REG_PATTERN_LO:     words[0] = value;
        REG_PATTERN_MID_LO: words[1] = value;
        REG_PATTERN_MID_HI: words[2] = value;
        REG_PATTERN_HI:     words[3] = value;
        default: ;
      endcase
    endfunction

    // Lengths beyond the stored bytes or the parameter saturate.
    function int unsigned eff_len();
      int unsigned n;
      n = length_reg;
      if (n > PATTERN_MAX) n = PATTERN_MAX;
      if (n > BYTES_STORED) n = BYTES_STORED;
      return n;
    endfunction

    function logic [7:0] pat_at(int unsigned idx);
      return words[idx / 8][(idx % 8) * 8 +: 8];
    endfunction

    // Every position right after a reachable star is reachable too.
    function logic [32:0] star_close(logic [32:0] set, int unsigned len);
      for (int unsigned i = 0; i < len; i++) begin
        if (set[i] && pat_at(i) == STAR_BYTE) set[i + 1] = 1'b1;
      end
      return set;
    endfunction

    // Advances the position set by one accepted name word.
    function void note_word(logic [7:0] name_byte, logic name_end);
      int unsigned len;
      logic [32:0] cur;
      logic [32:0] nxt;
      logic [32:0] fin;
      len = eff_len();
      cur = star_close(reach, len);
      nxt = '0;
      for (int unsigned i = 0; i < len; i++) begin
        if (cur[i]) begin
          if (pat_at(i) == STAR_BYTE) nxt[i] = 1'b1;
          else if (pat_at(i) == name_byte) nxt[i + 1] = 1'b1;
        end
      end
      // A hidden name only matches a pattern that starts with a dot.
      if (at_start && name_byte == DOT_BYTE && !(len > 0 && pat_at(0) == DOT_BYTE)) nxt = '0;
      if (name_end) begin
        fin = star_close(nxt, len);
        pending_verdicts.push_back(fin[len]);
        reach    = 33'd1;
        at_start = 1'b1;
      end else begin
        reach    = nxt;
        at_start = 1'b0;
      end
    endfunction

    function void check_verdict(logic actual);
      logic expected;
      if (pending_verdicts.size() == 0) begin
        fails++;
        $display("%0t unexpected verdict: expected none, actual %0b", $time, actual);
      end else begin
        expected = pending_verdicts.pop_front();
        if (actual !== expected) begin
          fails++;
          $display("%0t name_matches mismatch: expected %0b, actual %0b", $time, expected,
                   actual);
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            in_name_byte;
  logic                  in_name_end;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_name_matches;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  glob_verdict_tracker tracker;
  int unsigned         word_count;
  bit                  quiet;
  int unsigned         stall_left;

  glob_star_name_matcher #(.PATTERN_MAX(PATTERN_MAX)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_name_byte     (in_name_byte),
    .in_name_end      (in_name_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_name_matches (out_name_matches),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Register write: setup cycle, then access cycle until pready.
  task automatic apb_write(logic [2:0] idx, logic [63:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.write_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_pattern(pattern_t pb, logic [5:0] len_code);
    logic [63:0] w;
    apb_write(REG_PATTERN_LENGTH, {58'd0, len_code});
    for (int q = 0; q < 4; q++) begin
      for (int b = 0; b < 8; b++) w[b * 8 +: 8] = pb[q * 8 + b];
      apb_write(REG_PATTERN_LO + q[2:0], w);
    end
  endtask

  // Drains all pending verdicts and lets the pipeline empty out.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sends one word, with an optional idle burst in front of it.
  task automatic send_word(logic [7:0] name_byte, logic name_end);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_name_byte <= name_byte;
    in_name_end  <= name_end;
    do @(posedge clk); while (in_stall);
    tracker.note_word(name_byte, name_end);
    word_count++;
  endtask

  task automatic send_name(byte_q_t nm);
    foreach (nm[i]) send_word(nm[i], i == nm.size() - 1);
  endtask

  function automatic pattern_t from_text(string s);
    pattern_t pb;
    foreach (pb[i]) pb[i] = 8'h00;
    for (int i = 0; i < s.len(); i++) pb[i] = s[i];
    return pb;
  endfunction

  // Name filler: mostly pattern letters, with dots, stars, zeros and noise.
  function automatic logic [7:0] fill_byte();
    case ($urandom_range(0, 9))
      0:       return DOT_BYTE;
      1:       return STAR_BYTE;
      2:       return 8'h00;
      3, 4:    return 8'($urandom_range(0, 255));
      default: return 8'h61 + 8'($urandom_range(0, 1));
    endcase
  endfunction

  task automatic random_pattern(output pattern_t pb, output logic [5:0] len_code);
    bit noisy;
    case ($urandom_range(0, 15))
      0:       len_code = 6'd0;
      1:       len_code = 6'($urandom_range(33, 63));
      2, 3:    len_code = 6'($urandom_range(17, 32));
      default: len_code = 6'($urandom_range(1, 10));
    endcase
    noisy = ($urandom_range(0, 7) == 0);
    foreach (pb[i]) begin
      if (noisy) pb[i] = 8'($urandom_range(0, 255));
      else if ($urandom_range(0, 9) < 3) pb[i] = STAR_BYTE;
      else pb[i] = fill_byte();
    end
  endtask

  // Well-formed names follow the pattern with random star runs; some are
  // then broken by one edit or a leading dot. Noise names are random words.
  function automatic byte_q_t build_name(bit well_formed);
    byte_q_t     nm;
    int unsigned n;
    int unsigned k;
    logic [7:0]  p;
    n = tracker.eff_len();
    if (!well_formed) begin
      repeat ($urandom_range(1, 8)) nm.push_back(fill_byte());
    end else begin
      for (int unsigned i = 0; i < n; i++) begin
        p = tracker.pat_at(i);
        if (p == STAR_BYTE) repeat ($urandom_range(0, 3)) nm.push_back(fill_byte());
        else nm.push_back(p);
      end
      if ($urandom_range(0, 3) == 0 && nm.size() > 0) begin
        k = $urandom_range(0, nm.size() - 1);
        case ($urandom_range(0, 2))
          0:       nm[k] = fill_byte();
          1:       nm.delete(k);
          default: nm.insert(k, fill_byte());
        endcase
      end
      if ($urandom_range(0, 7) == 0) nm.push_front(DOT_BYTE);
    end
    if (nm.size() == 0) nm.push_back(fill_byte());
    return nm;
  endfunction

  // Verdicts are sampled at the rising edge.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) tracker.check_verdict(out_name_matches);
    end
  end

  // Receiver stalls in random bursts, none in the quiet tail.
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 11);
      end
    end
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("glob_star_name_matcher: mismatch");
    $finish;
  end

  initial begin
    pattern_t    pb;
    logic [5:0]  len_code;
    byte_q_t     nm;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_name_byte = '0;
    in_name_end  = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    word_count   = 0;
    quiet        = 1'b0;
    tracker      = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The empty pattern after reset matches nothing, a zero byte included.
    send_name('{8'h61});
    send_name('{8'h00});
    settle();

    // A write to the unused slot leaves the pattern alone.
    apb_write(REG_UNUSED, {$urandom, $urandom});
    // A lone star takes anything but a hidden name.
    load_pattern(from_text("*"), 6'd1);
    send_name('{DOT_BYTE});
    send_name('{8'h78});
    send_name('{8'hFF});
    settle();

    // A pattern with a leading dot admits a hidden name.
    load_pattern(from_text(".*"), 6'd2);
    send_name('{DOT_BYTE, 8'h61, 8'h62});
    send_name('{8'h61, 8'h62});
    settle();

    // Backtracking over a repeated prefix must not drop bytes.
    load_pattern(from_text("*aab"), 6'd4);
    send_name('{8'h61, 8'h61, 8'h61, 8'h62});
    send_name('{8'h61, 8'h61, 8'h62});
    settle();

    // A zero byte in the pattern matches only a zero byte.
    pb = from_text("a?*b");
    pb[1] = 8'h00;
    load_pattern(pb, 6'd4);
    send_name('{8'h61, 8'h00, 8'h7A, 8'h62});
    send_name('{8'h61, 8'h62});
    settle();

    // An oversized length saturates to the full store of stars.
    foreach (pb[i]) pb[i] = STAR_BYTE;
    load_pattern(pb, 6'd63);
    send_name('{DOT_BYTE, 8'h71});
    send_name('{8'h71, 8'h71});
    settle();

    // Random phases: a new pattern, then a run of mostly well-formed names.
    while (word_count < TOTAL_WORDS) begin
      random_pattern(pb, len_code);
      load_pattern(pb, len_code);
      repeat ($urandom_range(5, 20)) begin
        if (word_count >= TOTAL_WORDS) break;
        nm = build_name($urandom_range(0, 4) != 0);
        quiet = (word_count >= QUIET_FROM);
        send_name(nm);
      end
      settle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.pending_verdicts.size() != 0) begin
      tracker.fails++;
      $display("%0t verdicts left over: expected 0, actual %0d", $time,
               tracker.pending_verdicts.size());
    end
    if (tracker.fails == 0) begin
      $display("glob_star_name_matcher: match");
    end else begin
      $display("glob_star_name_matcher: mismatch");
    end
    $finish;
  end

endmodule
